@@ hw/rtl/nrsh_pkg.sv @@
// ----------------------------------------------------------------------------
// nrsh_pkg
// Shared constants and controller/datapath interface types for the
// nearest ray/segment hit core.
// ----------------------------------------------------------------------------
package nrsh_pkg;

	localparam int MAX_WALLS = 1024;
	localparam int ADDR_W    = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int COUNT_W   = $clog2(MAX_WALLS + 1);
	localparam int WALL_W    = 128;
	localparam int PROD_W    = 68;
	localparam int U_ITERS   = 31;
	localparam int T_ITERS   = 17;
	localparam int ITER_W    = 5;

	localparam logic [30:0] U_SAT = 31'h7FFF_FFFF;

	// request codes
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_CAST   = 2'd2;

	// multiplier operand pairs
	localparam logic [2:0] MP_DEN_A = 3'd0;
	localparam logic [2:0] MP_DEN_B = 3'd1;
	localparam logic [2:0] MP_TN_A  = 3'd2;
	localparam logic [2:0] MP_TN_B  = 3'd3;
	localparam logic [2:0] MP_UN_A  = 3'd4;
	localparam logic [2:0] MP_UN_B  = 3'd5;
	localparam logic [2:0] MP_LX    = 3'd6;
	localparam logic [2:0] MP_LY    = 3'd7;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              cast_init;
		logic              dif_en;
		logic              mul_en;
		logic [2:0]        mul_sel;
		logic              norm_en;
		logic              test_en;
		logic              div_load_u;
		logic              div_load_t;
		logic              div_step;
		logic              take;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic sat;
		logic better;
	} stat_t;

endpackage

@@ hw/rtl/nrsh_dp.sv @@
// ----------------------------------------------------------------------------
// nrsh_dp
// Datapath: wall memory, difference registers, shared multiplier, sign
// normalize, hit tests, restoring divider, nearest-hit registers.
// ----------------------------------------------------------------------------
module nrsh_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nrsh_pkg::cmd_t        cmd,
	output nrsh_pkg::stat_t       stat,
	input  logic signed [31:0]    point_a_x,
	input  logic signed [31:0]    point_a_y,
	input  logic signed [31:0]    point_b_x,
	input  logic signed [31:0]    point_b_y,
	output logic                  hit,
	output logic signed [31:0]    hit_x,
	output logic signed [31:0]    hit_y,
	output logic [30:0]           ray_param
);

	logic [nrsh_pkg::WALL_W-1:0] mem [nrsh_pkg::MAX_WALLS];
	logic [nrsh_pkg::WALL_W-1:0] rd_q;

	logic signed [31:0] ox_q, oy_q, bx_q, by_q;
	logic signed [32:0] dy12_q, dx12_q, dya_q, dxa_q, ex_q, ey_q;
	logic signed [33:0] op_a, op_b;
	logic signed [nrsh_pkg::PROD_W-1:0] prod_s1, hold_q, den_q, tn_q, un_q, comb_diff;
	logic [2:0] sel_s1;
	logic       vld_s1;
	logic [67:0] rem_q;
	logic [30:0] shin_q, quo_q, best_u_q, cand_u;
	logic [68:0] trial;
	logic        sat_q, found_q;
	logic signed [31:0] best_x_q, best_y_q;
	logic signed [31:0] x1, y1;
	logic [31:0] lerp_m;
	logic [32:0] ex_mag, ey_mag;

	assign x1 = rd_q[127:96];
	assign y1 = rd_q[95:64];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= {point_a_x, point_a_y, point_b_x, point_b_y};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
		end
	end

	assign ex_mag = ex_q[32] ? 33'(-ex_q) : 33'(ex_q);
	assign ey_mag = ey_q[32] ? 33'(-ey_q) : 33'(ey_q);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			nrsh_pkg::MP_DEN_A: begin op_a = 34'(dy12_q); op_b = 34'(bx_q); end
			nrsh_pkg::MP_DEN_B: begin op_a = 34'(dx12_q); op_b = 34'(by_q); end
			nrsh_pkg::MP_TN_A:  begin op_a = 34'(dya_q);  op_b = 34'(bx_q); end
			nrsh_pkg::MP_TN_B:  begin op_a = 34'(dxa_q);  op_b = 34'(by_q); end
			nrsh_pkg::MP_UN_A:  begin op_a = 34'(dy12_q); op_b = 34'(dxa_q); end
			nrsh_pkg::MP_UN_B:  begin op_a = 34'(dx12_q); op_b = 34'(dya_q); end
			nrsh_pkg::MP_LX: begin
				op_a = $signed({17'b0, quo_q[16:0]});
				op_b = $signed({1'b0, ex_mag});
			end
			default: begin
				op_a = $signed({17'b0, quo_q[16:0]});
				op_b = $signed({1'b0, ey_mag});
			end
		endcase
	end

	assign comb_diff = hold_q - prod_s1;
	assign lerp_m    = prod_s1[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= op_a * op_b;
			sel_s1  <= cmd.mul_sel;
		end
	end

	assign cand_u      = sat_q ? nrsh_pkg::U_SAT : quo_q;
	assign trial       = {rem_q, shin_q[30]} - {1'b0, den_q};

	// hit tests on normalized (den >= 0) values
	always_comb begin
		stat.skip   = (den_q == '0) || tn_q[nrsh_pkg::PROD_W-1] || un_q[nrsh_pkg::PROD_W-1]
			|| (tn_q > den_q);
		stat.sat    = {15'b0, un_q} >= {den_q, 15'b0};
		stat.better = !found_q || (cand_u < best_u_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			best_u_q <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
		end else if (cmd.cast_init) begin
			found_q  <= 1'b0;
			best_u_q <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
		end else begin
			if (cmd.take) begin
				found_q  <= 1'b1;
				best_u_q <= cand_u;
			end
			if (vld_s1 && sel_s1 == nrsh_pkg::MP_LX) begin
				best_x_q <= ex_q[32] ? x1 - $signed(lerp_m) : x1 + $signed(lerp_m);
			end
			if (vld_s1 && sel_s1 == nrsh_pkg::MP_LY) begin
				best_y_q <= ey_q[32] ? y1 - $signed(lerp_m) : y1 + $signed(lerp_m);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cast_init) begin
			ox_q <= point_a_x;
			oy_q <= point_a_y;
			bx_q <= point_b_x;
			by_q <= point_b_y;
		end
		if (cmd.dif_en) begin
			dy12_q <= 33'(y1) - 33'($signed(rd_q[31:0]));
			dx12_q <= 33'(x1) - 33'($signed(rd_q[63:32]));
			dya_q  <= 33'(y1) - 33'(oy_q);
			dxa_q  <= 33'(x1) - 33'(ox_q);
			ex_q   <= 33'($signed(rd_q[63:32])) - 33'(x1);
			ey_q   <= 33'($signed(rd_q[31:0])) - 33'(y1);
		end
		if (vld_s1) begin
			case (sel_s1) inside
				nrsh_pkg::MP_DEN_A, nrsh_pkg::MP_TN_A, nrsh_pkg::MP_UN_A: hold_q <= prod_s1;
				nrsh_pkg::MP_DEN_B: den_q <= comb_diff;
				nrsh_pkg::MP_TN_B:  tn_q  <= comb_diff;
				nrsh_pkg::MP_UN_B:  un_q  <= comb_diff;
				default: ;
			endcase
		end
		if (cmd.norm_en && den_q[nrsh_pkg::PROD_W-1]) begin
			den_q <= -den_q;
			tn_q  <= -tn_q;
			un_q  <= -un_q;
		end
		if (cmd.test_en) begin
			sat_q <= stat.sat;
		end
		if (cmd.div_load_u) begin
			rem_q  <= {15'b0, un_q[67:15]};
			shin_q <= {un_q[14:0], 16'b0};
			quo_q  <= '0;
		end else if (cmd.div_load_t) begin
			rem_q  <= {1'b0, tn_q[67:1]};
			shin_q <= {tn_q[0], 30'b0};
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			if (!trial[68]) begin
				rem_q <= trial[67:0];
			end else begin
				rem_q <= {rem_q[66:0], shin_q[30]};
			end
			shin_q <= {shin_q[29:0], 1'b0};
			quo_q  <= {quo_q[29:0], !trial[68]};
		end
	end

	assign hit       = found_q;
	assign hit_x     = best_x_q;
	assign hit_y     = best_y_q;
	assign ray_param = best_u_q;

endmodule

@@ hw/rtl/nrsh_ctrl.sv @@
// ----------------------------------------------------------------------------
// nrsh_ctrl
// Controller: request decode, wall count, overflow flag, per-wall
// sequencing of the datapath.
// ----------------------------------------------------------------------------
module nrsh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            req_type,
	input  nrsh_pkg::stat_t       stat,
	output nrsh_pkg::cmd_t        cmd,
	output logic                  busy,
	output logic                  done,
	output logic                  table_overflowed
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_DIFF = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_NORM = 4'd4;
	localparam logic [3:0] S_TEST = 4'd5;
	localparam logic [3:0] S_UDIV = 4'd6;
	localparam logic [3:0] S_CMP  = 4'd7;
	localparam logic [3:0] S_TDIV = 4'd8;
	localparam logic [3:0] S_LX   = 4'd9;
	localparam logic [3:0] S_LY   = 4'd10;
	localparam logic [3:0] S_LW   = 4'd11;
	localparam logic [3:0] S_NEXT = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0]                     state_q, state_d;
	logic [nrsh_pkg::COUNT_W-1:0]   count_q, k_q;
	logic [nrsh_pkg::ITER_W-1:0]    it_q;
	logic                           ovf_q, accept, full;

	assign accept = start && (state_q == S_IDLE);
	assign full   = (count_q == nrsh_pkg::COUNT_W'(nrsh_pkg::MAX_WALLS));

	always_comb begin
		cmd         = '0;
		cmd.wr_addr = count_q[nrsh_pkg::ADDR_W-1:0];
		cmd.rd_addr = k_q[nrsh_pkg::ADDR_W-1:0];
		cmd.mul_sel = it_q[2:0];
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_type == nrsh_pkg::REQ_APPEND) begin
					cmd.wr_en = !full;
				end
				if (accept && req_type == nrsh_pkg::REQ_CAST) begin
					cmd.cast_init = 1'b1;
					state_d = (count_q == '0) ? S_DONE : S_RD;
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.dif_en = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = (it_q < nrsh_pkg::ITER_W'(6));
				if (it_q == nrsh_pkg::ITER_W'(6)) state_d = S_NORM;
			end
			S_NORM: begin
				cmd.norm_en = 1'b1;
				state_d = S_TEST;
			end
			S_TEST: begin
				cmd.test_en = 1'b1;
				if (stat.skip) begin
					state_d = S_NEXT;
				end else if (stat.sat) begin
					state_d = S_CMP;
				end else begin
					cmd.div_load_u = 1'b1;
					state_d = S_UDIV;
				end
			end
			S_UDIV: begin
				cmd.div_step = 1'b1;
				if (it_q == nrsh_pkg::ITER_W'(nrsh_pkg::U_ITERS - 1)) state_d = S_CMP;
			end
			S_CMP: begin
				if (stat.better) begin
					cmd.take = 1'b1;
					cmd.div_load_t = 1'b1;
					state_d = S_TDIV;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_TDIV: begin
				cmd.div_step = 1'b1;
				if (it_q == nrsh_pkg::ITER_W'(nrsh_pkg::T_ITERS - 1)) state_d = S_LX;
			end
			S_LX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = nrsh_pkg::MP_LX;
				state_d = S_LY;
			end
			S_LY: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = nrsh_pkg::MP_LY;
				state_d = S_LW;
			end
			S_LW: begin
				state_d = S_NEXT;
			end
			S_NEXT: begin
				state_d = (k_q + 1'b1 == count_q) ? S_DONE : S_RD;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q     <= '0;
			it_q    <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && req_type == nrsh_pkg::REQ_APPEND) begin
				if (full) ovf_q <= 1'b1;
				else count_q <= count_q + 1'b1;
			end
			if (accept && req_type == nrsh_pkg::REQ_CLEAR) begin
				count_q <= '0;
			end
			if (cmd.cast_init) k_q <= '0;
			else if (state_q == S_NEXT) k_q <= k_q + 1'b1;
			if (state_d != state_q) it_q <= '0;
			else it_q <= it_q + 1'b1;
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign done             = (state_q == S_DONE);
	assign table_overflowed = ovf_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nrsh_pkg::COUNT_W'(nrsh_pkg::MAX_WALLS)) else $error("wall count overrun");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (k_q < count_q)) else $error("read of unwritten wall");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q) else $error("overflow flag dropped");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !busy) else $error("append while busy");

endmodule

@@ hw/rtl/nearest_ray_segment_hit_core.sv @@
// ----------------------------------------------------------------------------
// nearest_ray_segment_hit_core
// Nearest-hit ray caster over a table of Q16.16 wall segments.
// ----------------------------------------------------------------------------
// Usage: drive req_type and the four point fields with start high; the item
// is taken on a clock edge where busy is low. Append and clear items give
// no result; busy stays low. Appends past the table capacity are dropped
// and set the sticky table_overflowed flag. A cast item raises busy and
// visits each stored wall in order. Per wall: read, differences, six
// products on one shared multiplier, sign normalize and tests; a wall that
// passes adds a compare, preceded by a 31-step divide unless the quotient
// saturates; a new nearest hit adds a 17-step divide and the two
// interpolation products. The per-wall cost is set by the shared multiplier
// and the bit-serial divider; a cast on an empty table goes straight to
// done. The result appears for exactly one cycle with done high, then busy
// drops. The receiver cannot stall; it must take the result on that cycle.
// Reset empties the table and clears the overflow flag; no memory sweep is
// needed.
// ----------------------------------------------------------------------------
module nearest_ray_segment_hit_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] point_a_x,
	input  logic signed [31:0] point_a_y,
	input  logic signed [31:0] point_b_x,
	input  logic signed [31:0] point_b_y,
	output logic               done,
	output logic               hit,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic [30:0]        ray_param,
	output logic               table_overflowed
);

	nrsh_pkg::cmd_t  cmd;
	nrsh_pkg::stat_t stat;

	nrsh_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.req_type         (req_type),
		.stat             (stat),
		.cmd              (cmd),
		.busy             (busy),
		.done             (done),
		.table_overflowed (table_overflowed)
	);

	nrsh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.point_a_x (point_a_x),
		.point_a_y (point_a_y),
		.point_b_x (point_b_x),
		.point_b_y (point_b_y),
		.hit       (hit),
		.hit_x     (hit_x),
		.hit_y     (hit_y),
		.ray_param (ray_param)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_ray_segment_hit_core: a queue of append,
// clear and cast items feeds a clocked driver with random gaps. Each accepted
// cast is scored against an in-bench nearest-hit predictor, and the monitor
// compares every strobed result field by field.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         req;
		logic signed [31:0] ax, ay, bx, by;
	} item_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] x, y;
		logic [30:0]        u;
		logic               ovf;
	} hit_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         req_type = nrsh_pkg::REQ_APPEND;
	logic signed [31:0] point_a_x = '0, point_a_y = '0, point_b_x = '0, point_b_y = '0;
	logic               done, hit, table_overflowed;
	logic signed [31:0] hit_x, hit_y;
	logic [30:0]        ray_param;

	nearest_ray_segment_hit_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	item_t              pending_items[$];
	hit_rec_t           expected_hits[$];
	logic signed [31:0] wall_ax[nrsh_pkg::MAX_WALLS], wall_ay[nrsh_pkg::MAX_WALLS];
	logic signed [31:0] wall_bx[nrsh_pkg::MAX_WALLS], wall_by[nrsh_pkg::MAX_WALLS];
	int                 walls_stored = 0;
	bit                 overflow_seen = 0;
	int                 mismatches = 0, casts_done = 0, hits_seen = 0;
	int                 gap_left = 0;
	bit                 stim_done = 0;
	item_t              cur;

	function automatic logic signed [31:0] interp(input logic signed [127:0] p,
			input logic signed [127:0] tq, input logic signed [127:0] e);
		logic signed [127:0] m, r;
		m = ((e < 0 ? -e : e) * tq) >>> 16;
		r = e < 0 ? p - m : p + m;
		return r[31:0];
	endfunction

	function automatic hit_rec_t nearest_hit(input item_t c);
		hit_rec_t            best;
		logic signed [127:0] x1, y1, x2, y2, ox, oy, dx, dy, den, tn, un, uq, tq;
		logic [30:0]         u;
		best = '{1'b0, '0, '0, '0, overflow_seen};
		ox = c.ax; oy = c.ay; dx = c.bx; dy = c.by;
		for (int k = 0; k < walls_stored; k++) begin
			x1 = wall_ax[k]; y1 = wall_ay[k]; x2 = wall_bx[k]; y2 = wall_by[k];
			den = (y1 - y2) * dx - (x1 - x2) * dy;
			tn  = (y1 - oy) * dx - (x1 - ox) * dy;
			un  = (y1 - y2) * (x1 - ox) - (x1 - x2) * (y1 - oy);
			if (den == 0) continue;
			if (den < 0) begin
				den = -den; tn = -tn; un = -un;
			end
			if (tn < 0 || un < 0 || tn > den) continue;
			uq = (un <<< 16) / den;
			u = (uq > nrsh_pkg::U_SAT) ? nrsh_pkg::U_SAT : uq[30:0];
			if (!best.hit || u < best.u) begin
				tq = (tn <<< 16) / den;
				best.hit = 1'b1;
				best.u = u;
				best.x = interp(x1, tq, x2 - x1);
				best.y = interp(y1, tq, y2 - y1);
			end
		end
		return best;
	endfunction

	task automatic apply_item(input item_t c);
		case (c.req)
			nrsh_pkg::REQ_APPEND: begin
				if (walls_stored >= nrsh_pkg::MAX_WALLS) overflow_seen = 1;
				else begin
					wall_ax[walls_stored] = c.ax; wall_ay[walls_stored] = c.ay;
					wall_bx[walls_stored] = c.bx; wall_by[walls_stored] = c.by;
					walls_stored++;
				end
			end
			nrsh_pkg::REQ_CLEAR: walls_stored = 0;
			nrsh_pkg::REQ_CAST: expected_hits = {expected_hits, nearest_hit(c)};
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) apply_item(cur);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur = pending_items.pop_front();
					req_type <= cur.req;
					point_a_x <= cur.ax; point_a_y <= cur.ay;
					point_b_x <= cur.bx; point_b_y <= cur.by;
					start <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		hit_rec_t e;
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at %0t", $time);
			end else begin
				e = expected_hits.pop_front();
				casts_done++;
				if (hit) hits_seen++;
				if (hit !== e.hit || hit_x !== e.x || hit_y !== e.y || ray_param !== e.u
						|| table_overflowed !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cast %0d: exp hit=%0b x=%h y=%h u=%h ovf=%0b, got hit=%0b x=%h y=%h u=%h ovf=%0b",
							casts_done, e.hit, e.x, e.y, e.u, e.ovf,
							hit, hit_x, hit_y, ray_param, table_overflowed);
				end
			end
		end
	end

	function automatic logic signed [31:0] near_coord();
		return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
	endfunction

	function automatic logic signed [31:0] any_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return near_coord();
		endcase
	endfunction

	task automatic push(input logic [1:0] r, input logic signed [31:0] ax, ay, bx, by);
		item_t it;
		it = '{r, ax, ay, bx, by};
		pending_items = {pending_items, it};
	endtask

	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF, MINV = 32'sh8000_0000;

	initial begin
		int n;
		// empty table, then basic geometry
		push(nrsh_pkg::REQ_CAST, 0, 0, ONE, 0);
		push(nrsh_pkg::REQ_APPEND, 4 * ONE, -ONE, 4 * ONE, ONE);
		push(nrsh_pkg::REQ_CAST, 0, 0, ONE, 0);
		push(nrsh_pkg::REQ_CAST, 0, 0, 0, 0);
		push(nrsh_pkg::REQ_CAST, 0, 0, 0, ONE);
		push(nrsh_pkg::REQ_CAST, 0, 0, -ONE, 0);
		push(nrsh_pkg::REQ_CAST, 0, -ONE, ONE, 0);
		push(nrsh_pkg::REQ_CAST, 0, ONE, ONE, 0);
		push(nrsh_pkg::REQ_CAST, 4 * ONE, 0, ONE, 0);
		push(nrsh_pkg::REQ_APPEND, 4 * ONE, -ONE, 4 * ONE, ONE);
		push(nrsh_pkg::REQ_APPEND, 2 * ONE, -ONE, 2 * ONE, ONE);
		push(nrsh_pkg::REQ_CAST, 0, 0, ONE, 3);
		push(REQ_UNUSED, MAXV, MINV, MAXV, MINV);
		push(nrsh_pkg::REQ_CLEAR, 0, 0, 0, 0);
		push(nrsh_pkg::REQ_APPEND, MAXV, MINV, MAXV, MAXV);
		push(nrsh_pkg::REQ_APPEND, MINV, MINV, MAXV, MAXV);
		push(nrsh_pkg::REQ_APPEND, MINV, MAXV, MAXV, MINV);
		push(nrsh_pkg::REQ_CAST, 0, 0, 1, 0);
		push(nrsh_pkg::REQ_CAST, MINV, MINV, MAXV, MAXV);
		push(nrsh_pkg::REQ_CAST, MAXV, MAXV, MINV, -1);
		push(nrsh_pkg::REQ_CAST, 0, 0, MINV, MINV);
		push(nrsh_pkg::REQ_CLEAR, 0, 0, 0, 0);
		push(nrsh_pkg::REQ_CAST, 0, 0, ONE, 0);

		// random scenes: clear, 1 to 12 walls, 1 to 5 cast or unused items
		while (pending_items.size() < 555) begin
			push(nrsh_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
			n = $urandom_range(1, 12);
			repeat (n) begin
				if ($urandom_range(0, 7) == 0)
					push(nrsh_pkg::REQ_APPEND, any_coord(), any_coord(), any_coord(),
						any_coord());
				else
					push(nrsh_pkg::REQ_APPEND, near_coord(), near_coord(), near_coord(),
						near_coord());
			end
			repeat ($urandom_range(1, 5)) begin
				case ($urandom_range(0, 9))
					0: push(nrsh_pkg::REQ_CAST, any_coord(), any_coord(), any_coord(),
						any_coord());
					1: push(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
					2: push(nrsh_pkg::REQ_CAST, near_coord(), near_coord(),
						$urandom_range(0, 3) - 1, $urandom_range(0, 3) - 1);
					default: push(nrsh_pkg::REQ_CAST, near_coord() >>> 2, near_coord() >>> 2,
						near_coord(), near_coord());
				endcase
			end
		end

		// emptied table at the end
		push(nrsh_pkg::REQ_CLEAR, 0, 0, 0, 0);
		push(nrsh_pkg::REQ_CAST, 0, 0, ONE, ONE);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0);
		@(posedge clk);
		while (start || busy || expected_hits.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		stim_done = 1;
	end

	always @(posedge clk) begin
		if (stim_done) begin
			mismatches = mismatches + expected_hits.size();
			$display("casts checked: %0d, with a hit: %0d, walls in table at end: %0d",
				casts_done, hits_seen, walls_stored);
			$display("mismatches: %0d, overflow flag seen: %0b", mismatches, overflow_seen);
			if (mismatches == 0) $display("SUCCESS");
			else $display("FAILURE");
			$finish;
		end
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("FAILURE");
		$finish;
	end

endmodule
